// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the sequencer modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/fibs_pkg.sv =====
package fibs_pkg;

  localparam int CNT_W     = 4;
  localparam int CFG_W     = 5;
  localparam int BASE_W    = 10;
  localparam int IDX_W     = 11;
  localparam int CYC_W     = 32;
  localparam int MAX_COUNT = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_COLS       = 3'd0,
    REG_FILTER_ROWS       = 3'd1,
    REG_FILTERS_PER_SET   = 3'd2,
    REG_CHANNELS_PER_SET  = 3'd3,
    REG_CHANNEL_SET_COUNT = 3'd4,
    REG_FILTER_SET_COUNT  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              kind;
    logic [BASE_W-1:0] filter_base;
    logic [BASE_W-1:0] channel_base;
  } in_item_t;

  typedef struct packed {
    logic [CYC_W-1:0] cycle_number;
    logic [IDX_W-1:0] filter_num;
    logic [IDX_W-1:0] channel_num;
    logic [CNT_W-1:0] row_num;
    logic [CNT_W-1:0] col_num;
    logic             pass_last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] filter_cols;
    logic [CFG_W-1:0] filter_rows;
    logic [CFG_W-1:0] filters_per_set;
    logic [CFG_W-1:0] channels_per_set;
    logic [CFG_W-1:0] channel_set_count;
    logic [CFG_W-1:0] filter_set_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    filter_cols:       5'd3,
    filter_rows:       5'd3,
    filters_per_set:   5'd1,
    channels_per_set:  5'd1,
    channel_set_count: 5'd1,
    filter_set_count:  5'd1
  };

  // One emitted position, queued between the sequencer and the index stage.
  typedef struct packed {
    logic [CYC_W-1:0]  cycle;
    logic [BASE_W-1:0] base_filter;
    logic [BASE_W-1:0] base_channel;
    logic [CNT_W-1:0]  filter_pos;
    logic [CNT_W-1:0]  channel_pos;
    logic [CNT_W-1:0]  col_pos;
    logic [CNT_W-1:0]  row_pos;
    logic [CNT_W-1:0]  channel_set_pos;
    logic [CNT_W-1:0]  filter_set_pos;
    logic              last;
  } seq_entry_t;

  // Clamp a count register into 1..MAX_COUNT.
  function automatic logic [CFG_W-1:0] lim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MAX_COUNT)) r = CFG_W'(MAX_COUNT);
    return r;
  endfunction

  // Last counter value for a count register: lim(v) - 1.
  function automatic logic [CNT_W-1:0] last_pos(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] d;
    d = lim(v) - CFG_W'(1);
    return d[CNT_W-1:0];
  endfunction

endpackage

// ===== sv/fibs_front.sv =====
module fibs_front
  import fibs_pkg::*;
#(
  parameter int BURST_LEN = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       q_full,
  output logic       push_valid,
  output seq_entry_t push_data
);

  localparam int SW = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;

  logic              busy_r, busy_nxt;
  logic [BASE_W-1:0] base_f_r, base_f_nxt, base_c_r, base_c_nxt;
  logic [CNT_W-1:0]  gfp_r, gfp_nxt, gcp_r, gcp_nxt, gsp_r, gsp_nxt;
  logic [CNT_W-1:0]  fp_r, fp_nxt, cp_r, cp_nxt, sp_r, sp_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt, cset_r, cset_nxt, fset_r, fset_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [CYC_W-1:0]  cycle_r, cycle_nxt;

  logic [CNT_W-1:0]  lf, lc, ls, lrow, lcset, lfset;
  logic [CNT_W-1:0]  adv_fp, adv_cp, adv_sp;
  logic              accept, tick, burst_end, group_end, last;

  assign lf    = last_pos(cfg.filters_per_set);
  assign lc    = last_pos(cfg.channels_per_set);
  assign ls    = last_pos(cfg.filter_cols);
  assign lrow  = last_pos(cfg.filter_rows);
  assign lcset = last_pos(cfg.channel_set_count);
  assign lfset = last_pos(cfg.filter_set_count);

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign tick      = accept && (in_data.kind == KIND_TICK) && busy_r;
  assign burst_end = (step_r == SW'(BURST_LEN - 1));

  // Nested advance within the burst; saturate on the final combination.
  always_comb begin
    adv_fp = fp_r;
    adv_cp = cp_r;
    adv_sp = sp_r;
    if (fp_r < lf) begin
      adv_fp = fp_r + CNT_W'(1);
    end else begin
      adv_fp = '0;
      if (cp_r < lc) begin
        adv_cp = cp_r + CNT_W'(1);
      end else begin
        adv_cp = '0;
        if (sp_r < ls) begin
          adv_sp = sp_r + CNT_W'(1);
        end else begin
          adv_fp = lf;
          adv_cp = lc;
          adv_sp = ls;
        end
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    base_f_nxt = base_f_r;
    base_c_nxt = base_c_r;
    gfp_nxt   = gfp_r;
    gcp_nxt   = gcp_r;
    gsp_nxt   = gsp_r;
    fp_nxt    = fp_r;
    cp_nxt    = cp_r;
    sp_nxt    = sp_r;
    row_nxt   = row_r;
    cset_nxt  = cset_r;
    fset_nxt  = fset_r;
    step_nxt  = step_r;
    cycle_nxt = cycle_r;
    group_end = 1'b0;
    last      = 1'b0;
    if (accept && (in_data.kind == KIND_START) && !busy_r) begin
      base_f_nxt = in_data.filter_base;
      base_c_nxt = in_data.channel_base;
      gfp_nxt    = '0;
      gcp_nxt    = '0;
      gsp_nxt    = '0;
      fp_nxt     = '0;
      cp_nxt     = '0;
      sp_nxt     = '0;
      row_nxt    = '0;
      cset_nxt   = '0;
      fset_nxt   = '0;
      step_nxt   = '0;
      busy_nxt   = !((lf == '0) && (lc == '0) && (ls == '0));
    end else if (tick) begin
      if (cycle_r != '1) cycle_nxt = cycle_r + CYC_W'(1);
      if (burst_end) begin
        step_nxt = '0;
        if (fset_r < lfset) begin
          fset_nxt = fset_r + CNT_W'(1);
        end else begin
          fset_nxt = '0;
          if (cset_r < lcset) begin
            cset_nxt = cset_r + CNT_W'(1);
          end else begin
            cset_nxt = '0;
            if (row_r < lrow) begin
              row_nxt = row_r + CNT_W'(1);
            end else begin
              row_nxt   = '0;
              group_end = 1'b1;
            end
          end
        end
        if (group_end) begin
          gfp_nxt = adv_fp;
          gcp_nxt = adv_cp;
          gsp_nxt = adv_sp;
          if ((adv_fp >= lf) && (adv_cp >= lc) && (adv_sp >= ls)) begin
            busy_nxt = 1'b0;
            last     = 1'b1;
          end
        end
        // replay the burst from the group start
        fp_nxt = gfp_nxt;
        cp_nxt = gcp_nxt;
        sp_nxt = gsp_nxt;
      end else begin
        step_nxt = step_r + SW'(1);
        fp_nxt   = adv_fp;
        cp_nxt   = adv_cp;
        sp_nxt   = adv_sp;
      end
    end
  end

  always_comb begin
    push_valid                = tick;
    push_data.cycle           = cycle_r;
    push_data.base_filter     = base_f_r;
    push_data.base_channel    = base_c_r;
    push_data.filter_pos      = fp_r;
    push_data.channel_pos     = cp_r;
    push_data.col_pos         = sp_r;
    push_data.row_pos         = row_r;
    push_data.channel_set_pos = cset_r;
    push_data.filter_set_pos  = fset_r;
    push_data.last            = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      base_f_r <= '0;
      base_c_r <= '0;
      gfp_r    <= '0;
      gcp_r    <= '0;
      gsp_r    <= '0;
      fp_r     <= '0;
      cp_r     <= '0;
      sp_r     <= '0;
      row_r    <= '0;
      cset_r   <= '0;
      fset_r   <= '0;
      step_r   <= '0;
      cycle_r  <= CYC_W'(1);
    end else begin
      busy_r   <= busy_nxt;
      base_f_r <= base_f_nxt;
      base_c_r <= base_c_nxt;
      gfp_r    <= gfp_nxt;
      gcp_r    <= gcp_nxt;
      gsp_r    <= gsp_nxt;
      fp_r     <= fp_nxt;
      cp_r     <= cp_nxt;
      sp_r     <= sp_nxt;
      row_r    <= row_nxt;
      cset_r   <= cset_nxt;
      fset_r   <= fset_nxt;
      step_r   <= step_nxt;
      cycle_r  <= cycle_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_last_ends_pass, push_valid && push_data.last, !busy_r)
  `ASSERT_NEXT(a_cycle_advances, tick && (cycle_r != '1), cycle_r == $past(cycle_r) + CYC_W'(1))
  `ASSERT_ALWAYS(a_push_has_room, !(push_valid && q_full))

endmodule

// ===== sv/fibs_queue.sv =====
module fibs_queue
  import fibs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  seq_entry_t push_data,
  output logic       full,
  output logic       head_valid,
  output seq_entry_t head_data,
  input  logic       pop
);

  seq_entry_t entry_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_no_overflow, !(push && (count_r == 2'd2)))
  `ASSERT_ALWAYS(a_no_underflow, !(pop && (count_r == 2'd0)))
  `ASSERT_ALWAYS(a_count_bound, count_r != 2'd3)

endmodule

// ===== sv/fibs_back.sv =====
module fibs_back
  import fibs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  seq_entry_t head_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;
  logic [8:0] f_off, c_off;

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    f_off = 9'(head_data.filter_set_pos) * 9'(lim(cfg.filters_per_set));
    c_off = 9'(head_data.channel_set_pos) * 9'(lim(cfg.channels_per_set));
    out_data_nxt.cycle_number = head_data.cycle;
    out_data_nxt.filter_num   = IDX_W'(head_data.base_filter)
                              + IDX_W'(head_data.filter_pos) + IDX_W'(f_off);
    out_data_nxt.channel_num  = IDX_W'(head_data.base_channel)
                              + IDX_W'(head_data.channel_pos) + IDX_W'(c_off);
    out_data_nxt.row_num      = head_data.row_pos;
    out_data_nxt.col_num      = head_data.col_pos;
    out_data_nxt.pass_last    = head_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/filter_index_burst_sequencer_top.sv =====
// Filter-weight index sequencer. A start beat (kind = 1) latches the filter
// and channel bases and opens a pass; every tick beat (kind = 0) during a pass
// yields one (filter, channel, row, column) tuple with a saturating cycle
// number, and pass_last marks the final tuple. Starts while a pass runs, and
// ticks while idle, are dropped without a result. One beat is taken per clock
// while in_ready is high: the sequencer front updates all of its counters at
// once, pushes the tuple positions into a two-entry queue, and the back stage
// forms the indices (one small multiply and add each) into the output register.
// A tick result goes through the queue, then the output register. in_ready
// drops only while both queue entries are held by a stalled output side.
// Write the count registers over cfg_* only while no pass runs and all
// results are delivered; zero or oversize counts act as clamped to 1..16.
module filter_index_burst_sequencer_top
  import fibs_pkg::*;
#(
  parameter int BURST_LEN = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  logic       q_full, push_valid, head_valid, pop;
  seq_entry_t push_data, head_data;

  // Register file: one 5-bit count per index, writes outside the list drop.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_COLS:       cfg_nxt.filter_cols       = cfg_wdata;
        REG_FILTER_ROWS:       cfg_nxt.filter_rows       = cfg_wdata;
        REG_FILTERS_PER_SET:   cfg_nxt.filters_per_set   = cfg_wdata;
        REG_CHANNELS_PER_SET:  cfg_nxt.channels_per_set  = cfg_wdata;
        REG_CHANNEL_SET_COUNT: cfg_nxt.channel_set_count = cfg_wdata;
        REG_FILTER_SET_COUNT:  cfg_nxt.filter_set_count  = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify beats, run the burst/group counters.
  fibs_front #(
    .BURST_LEN (BURST_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Decouple the front from output back-pressure.
  fibs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Back: form filter/channel indices and hold the result beat.
  fibs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== sim/fibs_tuple_checker.sv =====
`timescale 1ns / 1ps
module fibs_tuple_checker
  import fibs_pkg::*;
#(
  parameter int BURST_LEN = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   tuples_pending,
  output logic                 pass_open,
  output int                   tuples_checked,
  output int                   passes_closed
);

  cfg_t              regs;
  logic [BASE_W-1:0] filt_base, chan_base;
  logic [CNT_W-1:0]  grp_filt, grp_chan, grp_col;
  logic [CNT_W-1:0]  cur_filt, cur_chan, cur_col;
  logic [CNT_W-1:0]  row, chan_set, filt_set;
  int unsigned       step_in_burst;
  logic [CYC_W-1:0]  next_cycle;
  out_item_t         tuple_fifo[$];

  function automatic int unsigned clamp_count(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_COUNT) return MAX_COUNT;
    return v;
  endfunction

  function automatic bit is_last(logic [CNT_W-1:0] pos, int unsigned n);
    return int'(pos) >= int'(n) - 1;
  endfunction

  function automatic bit combo_final(logic [CNT_W-1:0] fp, logic [CNT_W-1:0] cp,
                                     logic [CNT_W-1:0] sp);
    return is_last(fp, clamp_count(regs.filters_per_set)) &&
           is_last(cp, clamp_count(regs.channels_per_set)) &&
           is_last(sp, clamp_count(regs.filter_cols));
  endfunction

  function automatic string describe(out_item_t t);
    return $sformatf("cycle=%0d filter=%0d channel=%0d row=%0d col=%0d last=%0b",
                     t.cycle_number, t.filter_num, t.channel_num,
                     t.row_num, t.col_num, t.pass_last);
  endfunction

  task automatic clear_positions();
    grp_filt = '0; grp_chan = '0; grp_col = '0;
    cur_filt = '0; cur_chan = '0; cur_col = '0;
    row = '0; chan_set = '0; filt_set = '0;
    step_in_burst = 0;
  endtask

  // Filter, then channel, then column; pin all three once the last combination is hit.
  task automatic step_cursor();
    int unsigned p, q, s;
    p = clamp_count(regs.filters_per_set);
    q = clamp_count(regs.channels_per_set);
    s = clamp_count(regs.filter_cols);
    if (!is_last(cur_filt, p)) begin
      cur_filt++;
    end else begin
      cur_filt = '0;
      if (!is_last(cur_chan, q)) begin
        cur_chan++;
      end else begin
        cur_chan = '0;
        if (!is_last(cur_col, s)) begin
          cur_col++;
        end else begin
          cur_filt = CNT_W'(p - 1);
          cur_chan = CNT_W'(q - 1);
          cur_col  = CNT_W'(s - 1);
        end
      end
    end
  endtask

  task automatic take_beat(in_item_t b);
    out_item_t t;
    bit        group_end;
    if (b.kind == KIND_START) begin
      if (!pass_open) begin
        filt_base = b.filter_base;
        chan_base = b.channel_base;
        clear_positions();
        pass_open = !combo_final('0, '0, '0);
      end
    end else if (pass_open) begin
      t.cycle_number = next_cycle;
      t.filter_num   = IDX_W'(int'(filt_base) + int'(cur_filt) +
                              int'(filt_set) * int'(clamp_count(regs.filters_per_set)));
      t.channel_num  = IDX_W'(int'(chan_base) + int'(cur_chan) +
                              int'(chan_set) * int'(clamp_count(regs.channels_per_set)));
      t.row_num      = row;
      t.col_num      = cur_col;
      t.pass_last    = 1'b0;
      if (next_cycle != '1) next_cycle++;
      step_cursor();
      step_in_burst++;
      if (step_in_burst >= BURST_LEN) begin
        step_in_burst = 0;
        group_end = 1'b0;
        if (!is_last(filt_set, clamp_count(regs.filter_set_count))) begin
          filt_set++;
        end else begin
          filt_set = '0;
          if (!is_last(chan_set, clamp_count(regs.channel_set_count))) begin
            chan_set++;
          end else begin
            chan_set = '0;
            if (!is_last(row, clamp_count(regs.filter_rows))) begin
              row++;
            end else begin
              row = '0;
              group_end = 1'b1;
            end
          end
        end
        if (group_end) begin
          grp_filt = cur_filt;
          grp_chan = cur_chan;
          grp_col  = cur_col;
          if (combo_final(grp_filt, grp_chan, grp_col)) begin
            pass_open   = 1'b0;
            t.pass_last = 1'b1;
          end
        end
        // Replay the burst from the group origin.
        cur_filt = grp_filt;
        cur_chan = grp_chan;
        cur_col  = grp_col;
      end
      tuple_fifo.push_back(t);
    end
  endtask

  task automatic check_tuple(out_item_t got);
    out_item_t want;
    string     bad;
    if (tuple_fifo.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: tuple with nothing predicted: %s", $time, describe(got));
      return;
    end
    want = tuple_fifo.pop_front();
    tuples_checked++;
    if (want.pass_last) passes_closed++;
    bad = "";
    if (got.cycle_number !== want.cycle_number) bad = {bad, " cycle_number"};
    if (got.filter_num !== want.filter_num)     bad = {bad, " filter_num"};
    if (got.channel_num !== want.channel_num)   bad = {bad, " channel_num"};
    if (got.row_num !== want.row_num)           bad = {bad, " row_num"};
    if (got.col_num !== want.col_num)           bad = {bad, " col_num"};
    if (got.pass_last !== want.pass_last)       bad = {bad, " pass_last"};
    if (bad != "") begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: tuple mismatch in%s", $time, bad);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = CFG_RESET;
      filt_base = '0;
      chan_base = '0;
      clear_positions();
      pass_open = 1'b0;
      next_cycle = CYC_W'(1);
      tuple_fifo.delete();
      mismatch_count = 0;
      tuples_checked = 0;
      passes_closed = 0;
    end else begin
      if (out_valid && out_ready) check_tuple(out_data);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FILTER_COLS:       regs.filter_cols       = cfg_wdata;
          REG_FILTER_ROWS:       regs.filter_rows       = cfg_wdata;
          REG_FILTERS_PER_SET:   regs.filters_per_set   = cfg_wdata;
          REG_CHANNELS_PER_SET:  regs.channels_per_set  = cfg_wdata;
          REG_CHANNEL_SET_COUNT: regs.channel_set_count = cfg_wdata;
          REG_FILTER_SET_COUNT:  regs.filter_set_count  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_beat(in_data);
    end
    tuples_pending = tuple_fifo.size();
  end

endmodule

// ===== sim/tb_filter_index_burst_sequencer_top.sv =====
`timescale 1ns / 1ps
module tb_filter_index_burst_sequencer_top;
  import fibs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BEATS = 2000;
  localparam int BURST        = 4;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int   mismatch_count;
  int   tuples_pending;
  int   tuples_checked;
  int   passes_closed;
  logic pass_open;

  bit   idle_on = 1'b1;   // random gaps on both sides while set
  int   ready_hold = 0;
  int   clk_ticks = 0;
  int   beats_sent = 0;
  int   cfg_phases = 0;
  int   random_items = 0;

  always #10 clk = ~clk;

  filter_index_burst_sequencer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fibs_tuple_checker #(.BURST_LEN(BURST)) tuple_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .tuples_pending (tuples_pending),
    .pass_open      (pass_open),
    .tuples_checked (tuples_checked),
    .passes_closed  (passes_closed)
  );

  // Hard stop if the run hangs: no handshake loop may spin forever.
  always @(posedge clk) begin
    clk_ticks++;
    if (clk_ticks > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tuples still predicted",
               clk_ticks, tuples_pending);
      $display("filter_index_burst_sequencer_top verification failed");
      $finish;
    end
  end

  // Output back-pressure: random stall bursts, none started while idling is off.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Clamp a count register the way the block reads it (only used to size passes).
  function automatic int eff_count(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_COUNT) return MAX_COUNT;
    return v;
  endfunction

  // Ticks that one pass takes: each group moves the combination cursor by one burst,
  // and each group replays that burst for every row, channel set and filter set.
  function automatic int pass_length(cfg_t c);
    int combos;
    int groups;
    combos = eff_count(c.filters_per_set) * eff_count(c.channels_per_set) *
             eff_count(c.filter_cols);
    groups = (combos - 1 + BURST - 1) / BURST;
    return groups * eff_count(c.filter_rows) * eff_count(c.channel_set_count) *
           eff_count(c.filter_set_count) * BURST;
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'($urandom_range(MAX_COUNT + 1, 31));
      2:       return CFG_W'(MAX_COUNT);
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Redraw until the pass stays short; large counts still show up, just not all at once.
  function automatic cfg_t random_cfg();
    cfg_t c;
    do begin
      c.filter_cols       = pick_count();
      c.filter_rows       = pick_count();
      c.filters_per_set   = pick_count();
      c.channels_per_set  = pick_count();
      c.channel_set_count = pick_count();
      c.filter_set_count  = pick_count();
    end while (pass_length(c) > 400);
    return c;
  endfunction

  // Fixed corner settings: counts at their top, above range, and zero.
  function automatic cfg_t corner_cfg(int k);
    cfg_t c;
    c = '{filter_cols: 5'd1, filter_rows: 5'd1, filters_per_set: 5'd1,
          channels_per_set: 5'd1, channel_set_count: 5'd1, filter_set_count: 5'd1};
    case (k)
      0: c.filter_cols = 5'd16;
      1: begin
        c.filters_per_set   = 5'd31;
        c.channel_set_count = 5'd0;
        c.filter_set_count  = 5'd0;
        c.filter_rows       = 5'd0;
      end
      2: begin
        c.channels_per_set = 5'd16;
        c.filter_rows      = 5'd2;
      end
      3: begin
        c.filter_rows = 5'd16;
        c.filter_cols = 5'd3;
      end
      default: begin
        c.channel_set_count = 5'd16;
        c.filter_set_count  = 5'd16;
        c.filter_cols       = 5'd2;
      end
    endcase
    return c;
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BASE_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_start(logic [BASE_W-1:0] fb, logic [BASE_W-1:0] cb);
    in_item_t b;
    b.kind         = KIND_START;
    b.filter_base  = fb;
    b.channel_base = cb;
    return b;
  endfunction

  // Bases ride along on ticks too; the block must ignore them.
  function automatic in_item_t tick_beat();
    in_item_t b;
    b.kind         = KIND_TICK;
    b.filter_base  = BASE_W'($urandom);
    b.channel_base = BASE_W'($urandom);
    return b;
  endfunction

  // Call at a rising edge; returns at the edge that takes the beat. Valid stays
  // high across back-to-back beats and only drops for a gap.
  task automatic send_beat(in_item_t b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Tick until the open pass is over. Drop valid after each beat and look at the
  // predicted pass state on the falling edge, when it has settled.
  task automatic close_pass();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pass_open) begin
      @(posedge clk);
      send_beat(tick_beat());
      in_valid <= 1'b0;
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted tuple, then let the two-stage pipe run dry.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tuples_pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all six count registers on consecutive edges; the block must be idle.
  task automatic apply_cfg(cfg_t c);
    cfg_reg_t idx;
    for (int i = 0; i <= int'(REG_FILTER_SET_COUNT); i++) begin
      idx = cfg_reg_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_FILTER_COLS:       cfg_wdata <= c.filter_cols;
        REG_FILTER_ROWS:       cfg_wdata <= c.filter_rows;
        REG_FILTERS_PER_SET:   cfg_wdata <= c.filters_per_set;
        REG_CHANNELS_PER_SET:  cfg_wdata <= c.channels_per_set;
        REG_CHANNEL_SET_COUNT: cfg_wdata <= c.channel_set_count;
        REG_FILTER_SET_COUNT:  cfg_wdata <= c.filter_set_count;
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  // One well-formed pass: a start, then exactly the ticks it needs, with now and
  // then a stray start in the middle that the block must drop.
  task automatic run_pass(cfg_t c);
    int n;
    n = pass_length(c);
    send_beat(make_start(pick_base(), pick_base()));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) send_beat(make_start(pick_base(), pick_base()));
      send_beat(tick_beat());
    end
    random_items += n + 1;
  endtask

  initial begin
    cfg_t c;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick while idle, a pass from the top bases at reset settings with
    // a start during it, then an idle tick afterward.
    send_beat(tick_beat());
    send_beat(make_start('1, '1));
    send_beat(make_start('0, '0));
    repeat (pass_length(CFG_RESET)) send_beat(tick_beat());
    close_pass();
    send_beat(tick_beat());

    // Directed: zero columns clamp to one, so with one filter and one channel
    // per set the pass is empty and the tick after it yields nothing.
    settle();
    c = CFG_RESET;
    c.filter_cols = '0;
    apply_cfg(c);
    send_beat(make_start('0, '0));
    send_beat(tick_beat());

    // Corner settings, one pass each with random bases.
    for (int k = 0; k < 5; k++) begin
      settle();
      apply_cfg(corner_cfg(k));
      run_pass(corner_cfg(k));
      close_pass();
    end

    // Random settings, a few passes each with some idle-tick noise between them.
    // Turn idling off for the last stretch so the block runs at full rate.
    while (random_items < RANDOM_BEATS) begin
      idle_on = (random_items < RANDOM_BEATS * 85 / 100) && ($urandom_range(0, 4) != 0);
      settle();
      c = random_cfg();
      apply_cfg(c);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) send_beat(tick_beat());
        run_pass(c);
        close_pass();
      end
    end

    idle_on = 1'b0;
    settle();

    $display("Covered %0d input beats under %0d register settings.", beats_sent, cfg_phases);
    $display("Checked %0d index tuples across %0d completed passes.",
             tuples_checked, passes_closed);
    if (mismatch_count == 0 && tuples_pending == 0) begin
      $display("filter_index_burst_sequencer_top verification clean");
    end else begin
      $display("%0d mismatches, %0d tuples never delivered", mismatch_count, tuples_pending);
      $display("filter_index_burst_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
